// ===== hw/rtl/cch_pkg.sv =====
// Shared types, constants and helper functions for the CJK character histogram.
`default_nettype none

package cch_pkg;

    // Counter width of the histogram bins and the character, CJK and file totals.
    localparam int COUNT_WIDTH = 32;
    // Width of the count fields carried on the result stream.
    localparam int OUT_CNT_W   = 32;
    // Width of a code point.
    localparam int PT_W        = 21;
    // Width of the distinct character total.
    localparam int DIST_W      = 17;

    // Exclusive bounds of the three CJK ranges.
    localparam logic [PT_W-1:0] UNI_LO_EXCL = 21'h04DFF;
    localparam logic [PT_W-1:0] UNI_HI_EXCL = 21'h09FA6;
    localparam logic [PT_W-1:0] EXA_LO_EXCL = 21'h033FF;
    localparam logic [PT_W-1:0] EXA_HI_EXCL = 21'h04DB6;
    localparam logic [PT_W-1:0] EXB_LO_EXCL = 21'h1FFFF;
    localparam logic [PT_W-1:0] EXB_HI_EXCL = 21'h2A6D7;

    // Highest legal Unicode scalar value.
    localparam logic [PT_W-1:0] MAX_POINT   = 21'h10FFFF;

    localparam int UNI_SIZE  = int'(UNI_HI_EXCL) - int'(UNI_LO_EXCL) - 1;
    localparam int EXA_SIZE  = int'(EXA_HI_EXCL) - int'(EXA_LO_EXCL) - 1;
    localparam int EXB_SIZE  = int'(EXB_HI_EXCL) - int'(EXB_LO_EXCL) - 1;
    localparam int BIN_DEPTH = UNI_SIZE + EXA_SIZE + EXB_SIZE;
    localparam int BIN_AW    = $clog2(BIN_DEPTH);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [PT_W-1:0]        point_t;
    typedef logic [BIN_AW-1:0]      bin_addr_t;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_EOF   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BLK_NONE = 2'd0,
        BLK_UNI  = 2'd1,
        BLK_EXA  = 2'd2,
        BLK_EXB  = 2'd3
    } blk_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;   // write zero to the bin at the clear pointer, advance it
        logic load;     // input transfer: decode the item and latch it
        logic mem_rd;   // read the latched bin address
        logic commit;   // update counters and the bin, load the result register
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // clear pointer sits on the last bin
    } status_t;

    typedef struct packed {
        blk_t      kind;
        bin_addr_t bin;
    } class_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + count_t'(1);
        return r;
    endfunction

    // Map a code point onto its CJK range and histogram address.
    function automatic class_t classify(input point_t c);
        class_t r;
        r.kind = BLK_NONE;
        r.bin  = '0;
        if (c > UNI_LO_EXCL && c < UNI_HI_EXCL) begin
            r.kind = BLK_UNI;
            r.bin  = BIN_AW'(c - (UNI_LO_EXCL + point_t'(1)));
        end
        else if (c > EXA_LO_EXCL && c < EXA_HI_EXCL) begin
            r.kind = BLK_EXA;
            r.bin  = BIN_AW'(c - (EXA_LO_EXCL + point_t'(1)) + point_t'(UNI_SIZE));
        end
        else if (c > EXB_LO_EXCL && c < EXB_HI_EXCL) begin
            r.kind = BLK_EXB;
            r.bin  = BIN_AW'(c - (EXB_LO_EXCL + point_t'(1))
                             + point_t'(UNI_SIZE + EXA_SIZE));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cch_ctrl.sv =====
// Controller state machine: clear pass, accept, bin read, commit.
`default_nettype none

module cch_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    input  cch_pkg::status_t status,
    output cch_pkg::ctrl_t   ctrl
);
    import cch_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: ctrl.clr_wr = 1'b1;
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_READ:  ctrl.mem_rd = 1'b1;
            ST_WRITE: ctrl.commit = out_free;
            default:  ctrl = '0;
        endcase
    end

    always_comb
    begin
        if (ctrl.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cch_datapath.sv =====
// Datapath: UTF-8 decoder, bin memory, saturating counters and result register.
`default_nettype none

module cch_datapath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  cch_pkg::ctrl_t      ctrl,
    output cch_pkg::status_t    status,
    input  wire  [31:0]         s_tdata,
    input  wire  [1:0]          s_tuser,
    output logic [167:0]        m_tdata,
    output logic [1:0]          m_tuser
);
    import cch_pkg::*;

    // Input fields.
    cmd_t      in_cmd;
    logic [7:0] in_byte;
    point_t    in_query;

    // Decoder state.
    point_t    pp_reg;
    point_t    pp_next;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    point_t    pp_shift;
    logic      dec_done;
    point_t    dec_cp;
    logic      cp_valid;
    class_t    cls;

    // Latched item.
    cmd_t      item_cmd_reg;
    logic      item_done_reg;
    point_t    item_cp_reg;
    blk_t      item_kind_reg;
    bin_addr_t item_bin_reg;

    // Bin memory and clear pointer.
    count_t    bin_mem [BIN_DEPTH];
    count_t    rd_data_reg;
    bin_addr_t clr_addr_reg;
    logic      mem_we;
    bin_addr_t mem_waddr;
    count_t    mem_wdata;

    // Totals.
    count_t    chars_reg;
    count_t    chars_next;
    count_t    cjk_reg;
    count_t    cjk_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    count_t    files_reg;
    count_t    files_next;
    logic      counted;
    logic      query_hit;
    count_t    bin_inc;

    // Result register.
    logic      out_done_reg;
    point_t    out_cp_reg;
    blk_t      out_blk_reg;
    logic [OUT_CNT_W-1:0] out_chars_reg;
    logic [OUT_CNT_W-1:0] out_cjk_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic [OUT_CNT_W-1:0] out_files_reg;
    logic [OUT_CNT_W-1:0] out_qcount_reg;
    logic      out_qvalid_reg;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_byte  = s_tdata[7:0];
    assign in_query = s_tdata[28:8];

    // UTF-8 decoder, one byte a transfer.
    always_comb
    begin
        pp_next   = pp_reg;
        pend_next = pend_reg;
        pp_shift  = {pp_reg[PT_W-7:0], in_byte[5:0]};
        dec_done  = 1'b0;
        dec_cp    = '0;
        unique case (in_cmd)
            CMD_BYTE:
            begin
                if (in_byte[7:6] == 2'b10)
                begin
                    // Drop a stray continuation byte.
                    if (pend_reg != 2'd0)
                    begin
                        pend_next = pend_reg - 2'd1;
                        if (pend_reg == 2'd1)
                        begin
                            dec_done = 1'b1;
                            dec_cp   = pp_shift;
                            pp_next  = '0;
                        end
                        else
                        begin
                            pp_next = pp_shift;
                        end
                    end
                end
                else
                begin
                    pp_next   = '0;
                    pend_next = 2'd0;
                    if (!in_byte[7])
                    begin
                        dec_done = 1'b1;
                        dec_cp   = point_t'(in_byte);
                    end
                    else if (in_byte[7:5] == 3'b110)
                    begin
                        pp_next   = point_t'(in_byte[4:0]);
                        pend_next = 2'd1;
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        pp_next   = point_t'(in_byte[3:0]);
                        pend_next = 2'd2;
                    end
                    else if (in_byte[7:3] == 5'b11110)
                    begin
                        pp_next   = point_t'(in_byte[2:0]);
                        pend_next = 2'd3;
                    end
                end
            end
            CMD_EOF:
            begin
                pp_next   = '0;
                pend_next = 2'd0;
            end
            default:
            begin
                pp_next   = pp_reg;
                pend_next = pend_reg;
            end
        endcase
    end

    assign cp_valid = dec_done && (dec_cp <= MAX_POINT);
    assign cls      = classify((in_cmd == CMD_QUERY) ? in_query : dec_cp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg   <= '0;
            pend_reg <= 2'd0;
        end
        else if (ctrl.load)
        begin
            pp_reg   <= pp_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_cmd_reg  <= in_cmd;
            item_done_reg <= cp_valid;
            item_cp_reg   <= cp_valid ? dec_cp : '0;
            item_kind_reg <= cls.kind;
            item_bin_reg  <= cls.bin;
        end
    end

    // Clear pointer for the sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (ctrl.clr_wr && !status.clr_last)
            clr_addr_reg <= clr_addr_reg + bin_addr_t'(1);
    end

    assign status.clr_last = (clr_addr_reg == bin_addr_t'(BIN_DEPTH - 1));

    assign counted   = item_done_reg && (item_kind_reg != BLK_NONE);
    assign query_hit = (item_cmd_reg == CMD_QUERY) && (item_kind_reg != BLK_NONE);
    assign bin_inc   = sat_inc(rd_data_reg);

    assign mem_we    = ctrl.clr_wr || (ctrl.commit && counted);
    assign mem_waddr = ctrl.clr_wr ? clr_addr_reg : item_bin_reg;
    assign mem_wdata = ctrl.clr_wr ? count_t'(0) : bin_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        if (ctrl.mem_rd)
            rd_data_reg <= bin_mem[item_bin_reg];
    end

    always_comb
    begin
        chars_next = item_done_reg ? sat_inc(chars_reg) : chars_reg;
        cjk_next   = counted ? sat_inc(cjk_reg) : cjk_reg;
        dist_next  = dist_reg;
        if (counted && (rd_data_reg == '0) && (dist_reg < DIST_W'(BIN_DEPTH)))
            dist_next = dist_reg + DIST_W'(1);
        files_next = (item_cmd_reg == CMD_EOF) ? sat_inc(files_reg) : files_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
            cjk_reg   <= '0;
            dist_reg  <= '0;
            files_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            chars_reg <= chars_next;
            cjk_reg   <= cjk_next;
            dist_reg  <= dist_next;
            files_reg <= files_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_done_reg   <= item_done_reg;
            out_cp_reg     <= item_cp_reg;
            out_blk_reg    <= item_done_reg ? item_kind_reg : BLK_NONE;
            out_chars_reg  <= OUT_CNT_W'(chars_next);
            out_cjk_reg    <= OUT_CNT_W'(cjk_next);
            out_dist_reg   <= dist_next;
            out_files_reg  <= OUT_CNT_W'(files_next);
            out_qcount_reg <= query_hit ? OUT_CNT_W'(rd_data_reg) : '0;
            out_qvalid_reg <= (item_cmd_reg == CMD_QUERY);
        end
    end

    assign m_tdata = {out_qcount_reg, out_files_reg, out_dist_reg, out_cjk_reg,
                      out_chars_reg, out_blk_reg, out_cp_reg};
    assign m_tuser = {out_qvalid_reg, out_done_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/cjk_char_histogram.sv =====
// Top level of the UTF-8 character counter with a CJK code point histogram.
// An input transfer latches the item, the next state reads its bin, and commit loads the result register;
//   commit waits while an earlier result still waits there untaken.
// A new item is taken only after the previous one commits, as each item does a read-modify-write of its bin.
// Reset: counters and decoder clear at once; the bin memory is then swept to zero,
//   one bin a cycle over all BIN_DEPTH (70195) bins, and no item is taken until it ends.
`default_nettype none

module cjk_char_histogram (
    input  wire          clk,
    input  wire          rst_n,
    // Input stream.
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [31:0]  s_tdata,   // text_byte[7:0], query_point[28:8], zero fill
    input  wire  [1:0]   s_tuser,   // cmd[1:0]
    // Result stream.
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [167:0] m_tdata,   // code_point[20:0], block_index[22:21],
                                    // char_total[54:23], cjk_total[86:55],
                                    // distinct_total[103:87], file_total[135:104],
                                    // query_count[167:136]
    output logic [1:0]   m_tuser    // char_done[0], query_valid[1]
);
    import cch_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    // Controller: sequences the clear sweep, then accept, bin read and commit.
    cch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // Datapath: decoder, bin memory, saturating totals, result register.
    cch_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // No input transfer while the clear sweep still writes bins.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clr_wr |-> !s_tready)
        else $error("input accepted during clear sweep");

    // Every accepted item is followed directly by its bin read.
    a_read_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> ctrl.mem_rd)
        else $error("bin read did not follow accept");

    // A commit always leaves a result on offer.
    a_commit_offers_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> m_tvalid)
        else $error("commit without result valid");

    // A commit never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.commit && m_tvalid) |-> m_tready)
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ===== sim/cjk_char_histogram_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 character counter and its CJK histogram.
module cjk_char_histogram_tb;
    import cch_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 900;
    // Upper bound on the run length, which includes the bin sweep after reset.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 100;

    // Inclusive ends of the three counted ranges and of Unicode itself.
    localparam logic [20:0] UNI_FIRST   = 21'h04E00;
    localparam logic [20:0] UNI_LAST    = 21'h09FA5;
    localparam logic [20:0] EXA_FIRST   = 21'h03400;
    localparam logic [20:0] EXA_LAST    = 21'h04DB5;
    localparam logic [20:0] EXB_FIRST   = 21'h20000;
    localparam logic [20:0] EXB_LAST    = 21'h2A6D6;
    localparam logic [20:0] LAST_SCALAR = 21'h10FFFF;

    // One result as the block should present it.
    typedef struct packed {
        logic        char_done;
        logic        query_valid;
        logic [20:0] code_point;
        blk_t        blk;
        logic [31:0] char_total;
        logic [31:0] cjk_total;
        logic [16:0] distinct_total;
        logic [31:0] file_total;
        logic [31:0] query_count;
    } tally_t;

    // Tracks decoder state, totals and per-point counts, and queues the results due.
    class CharTallyScoreboard;
        tally_t      due_totals[$];
        count_t      bin_tally[int unsigned];
        logic [20:0] partial;
        int unsigned pending;
        count_t      chars;
        count_t      cjk_chars;
        count_t      files;
        logic [16:0] distinct;
        int unsigned mismatches;
        int unsigned checked;
        int unsigned reports;

        function new();
            partial    = '0;
            pending    = 0;
            chars      = '0;
            cjk_chars  = '0;
            files      = '0;
            distinct   = '0;
            mismatches = 0;
            checked    = 0;
            reports    = 0;
        endfunction

        function blk_t block_of(input logic [20:0] c);
            if (c >= UNI_FIRST && c <= UNI_LAST)
                return BLK_UNI;
            if (c >= EXA_FIRST && c <= EXA_LAST)
                return BLK_EXA;
            if (c >= EXB_FIRST && c <= EXB_LAST)
                return BLK_EXB;
            return BLK_NONE;
        endfunction

        // Advance the UTF-8 decoder by one byte; return 1 when a character completes.
        function bit feed_byte(input logic [7:0] b, output logic [20:0] cp);
            cp = '0;
            if (b[7:6] == 2'b10) begin
                // A stray continuation byte is ignored.
                if (pending == 0)
                    return 1'b0;
                partial = {partial[14:0], b[5:0]};
                pending--;
                if (pending != 0)
                    return 1'b0;
                cp      = partial;
                partial = '0;
                return 1'b1;
            end
            // Any other byte drops an unfinished character first.
            partial = '0;
            pending = 0;
            if (!b[7]) begin
                cp = {13'b0, b};
                return 1'b1;
            end
            if (b[7:5] == 3'b110) begin
                partial = {16'b0, b[4:0]};
                pending = 1;
            end
            else if (b[7:4] == 4'b1110) begin
                partial = {17'b0, b[3:0]};
                pending = 2;
            end
            else if (b[7:3] == 5'b11110) begin
                partial = {18'b0, b[2:0]};
                pending = 3;
            end
            return 1'b0;
        endfunction

        // Apply one accepted input and queue the result it is due to produce.
        function void take_input(input cmd_t cmd, input logic [7:0] b, input logic [20:0] q);
            tally_t      r;
            logic [20:0] cp;
            blk_t        kind;
            r     = '0;
            r.blk = BLK_NONE;
            case (cmd)
                CMD_BYTE: begin
                    // Values past the end of Unicode are dropped uncounted.
                    if (feed_byte(b, cp) && cp <= LAST_SCALAR) begin
                        r.char_done  = 1'b1;
                        r.code_point = cp;
                        if (~&chars)
                            chars++;
                        kind  = block_of(cp);
                        r.blk = kind;
                        if (kind != BLK_NONE) begin
                            if (~&cjk_chars)
                                cjk_chars++;
                            if (!bin_tally.exists(cp))
                                bin_tally[cp] = '0;
                            if (bin_tally[cp] == '0 && distinct < 17'(BIN_DEPTH))
                                distinct++;
                            if (~&bin_tally[cp])
                                bin_tally[cp]++;
                        end
                    end
                end
                CMD_QUERY: begin
                    // A read leaves the decoder alone.
                    r.query_valid = 1'b1;
                    if (block_of(q) != BLK_NONE && bin_tally.exists(q))
                        r.query_count = 32'(bin_tally[q]);
                end
                CMD_EOF: begin
                    if (~&files)
                        files++;
                    partial = '0;
                    pending = 0;
                end
                default: ;
            endcase
            r.char_total     = 32'(chars);
            r.cjk_total      = 32'(cjk_chars);
            r.distinct_total = distinct;
            r.file_total     = 32'(files);
            due_totals.push_back(r);
        endfunction

        function void compare(input string field, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (reports < MAX_REPORTS)
                    $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
                reports++;
            end
        endfunction

        function void check_result(input logic [1:0] user, input logic [167:0] data);
            tally_t want;
            if (due_totals.size() == 0) begin
                mismatches++;
                if (reports < MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, data);
                reports++;
                return;
            end
            want = due_totals.pop_front();
            checked++;
            compare("char_done",      32'(want.char_done),      32'(user[0]));
            compare("query_valid",    32'(want.query_valid),    32'(user[1]));
            compare("code_point",     32'(want.code_point),     32'(data[20:0]));
            compare("block_index",    32'(want.blk),            32'(data[22:21]));
            compare("char_total",     want.char_total,          data[54:23]);
            compare("cjk_total",      want.cjk_total,           data[86:55]);
            compare("distinct_total", 32'(want.distinct_total), 32'(data[103:87]));
            compare("file_total",     want.file_total,          data[135:104]);
            compare("query_count",    want.query_count,         data[167:136]);
        endfunction
    endclass

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [31:0]    s_tdata  = '0;
    logic [1:0]     s_tuser  = CMD_NOP;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [167:0]   m_tdata;
    logic [1:0]     m_tuser;

    int unsigned    src_idle_pct  = 8;
    int unsigned    sink_idle_pct = 85;
    int unsigned    cycle_count   = 0;
    int unsigned    items_sent    = 0;
    int unsigned    reads_sent    = 0;
    logic [20:0]    hot_points[16];
    logic [20:0]    last_point    = '0;
    CharTallyScoreboard tally_sb;

    cjk_char_histogram i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the result side at random; the rate follows the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tally_sb.check_result(m_tuser, m_tdata);
    end

    // Drive one item, idling first at the current rate; hold it until the transfer.
    task automatic push_item(input cmd_t cmd, input logic [7:0] b, input logic [20:0] q);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, q, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tally_sb.take_input(cmd, b, q);
        if (cmd != CMD_NOP)
            items_sent++;
        if (cmd == CMD_QUERY)
            reads_sent++;
    endtask

    // Unused fields carry random values so that the block is seen to ignore them.
    task automatic push_byte(input logic [7:0] b);
        push_item(CMD_BYTE, b, 21'($urandom));
    endtask

    task automatic push_query(input logic [20:0] q);
        push_item(CMD_QUERY, 8'($urandom), q);
    endtask

    // Send the first keep bytes of an nbytes-long encoding of cp; more bytes than
    // the value needs give an overlong form. Now and then slip a read in mid-character.
    task automatic push_point(input logic [20:0] cp, input int nbytes, input int keep);
        logic [7:0] seq[4];
        seq = '{default: 8'h00};
        case (nbytes)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) begin
            if (i != 0 && $urandom_range(19) == 0)
                push_query(hot_points[$urandom_range(15)]);
            push_byte(seq[i]);
        end
    endtask

    function automatic int min_len(input logic [20:0] cp);
        if (cp < 21'h80)
            return 1;
        if (cp < 21'h800)
            return 2;
        if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    // Favour CJK points, a small hot set so that bins climb, and range edges.
    function automatic logic [20:0] pick_point();
        case ($urandom_range(9))
            0:       return 21'($urandom_range(127));
            1, 2:    return hot_points[$urandom_range(15)];
            3:       return 21'($urandom_range(UNI_LAST, UNI_FIRST));
            4:       return 21'($urandom_range(EXA_LAST, EXA_FIRST));
            5:       return 21'($urandom_range(EXB_LAST, EXB_FIRST));
            6: begin
                case ($urandom_range(17))
                    0:       return UNI_FIRST - 21'd1;
                    1:       return UNI_FIRST;
                    2:       return UNI_LAST;
                    3:       return UNI_LAST + 21'd1;
                    4:       return EXA_FIRST - 21'd1;
                    5:       return EXA_FIRST;
                    6:       return EXA_LAST;
                    7:       return EXA_LAST + 21'd1;
                    8:       return EXB_FIRST - 21'd1;
                    9:       return EXB_FIRST;
                    10:      return EXB_LAST;
                    11:      return EXB_LAST + 21'd1;
                    12:      return LAST_SCALAR;
                    13:      return 21'h7F;
                    14:      return 21'h80;
                    15:      return 21'h7FF;
                    16:      return 21'hFFFF;
                    default: return 21'h10000;
                endcase
            end
            7:       return 21'($urandom_range(LAST_SCALAR));
            default: return 21'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Mostly whole characters with random content; the rest reads, file ends,
    // idle commands, cut-off sequences, noise and values beyond Unicode.
    task automatic random_action();
        logic [20:0] cp;
        int          n;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 72) begin
            cp = pick_point();
            n  = min_len(cp);
            if (n < 4 && $urandom_range(19) == 0)
                n++;
            push_point(cp, n, n);
            last_point = cp;
        end
        else if (pick < 77) begin
            cp = pick_point();
            n  = min_len(cp);
            if (n == 1)
                n = 3;
            push_point(cp, n, $urandom_range(n - 1, 1));
        end
        else if (pick < 87) begin
            case ($urandom_range(3))
                0, 1:    push_query(hot_points[$urandom_range(15)]);
                2:       push_query(last_point);
                default: push_query(21'($urandom));
            endcase
        end
        else if (pick < 90)
            push_item(CMD_EOF, 8'($urandom), 21'($urandom));
        else if (pick < 92)
            push_item(CMD_NOP, 8'($urandom), 21'($urandom));
        else if (pick < 97)
            push_byte(8'($urandom));
        else
            push_point(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
    endtask

    initial
    begin
        int target;
        tally_sb = new();
        // Pin the block ends into the hot set, fill the rest from the three ranges.
        hot_points[0] = UNI_FIRST;
        hot_points[1] = UNI_LAST;
        hot_points[2] = EXA_FIRST;
        hot_points[3] = EXA_LAST;
        hot_points[4] = EXB_FIRST;
        hot_points[5] = EXB_LAST;
        for (int i = 6; i < 16; i++) begin
            case (i % 3)
                0:       hot_points[i] = 21'($urandom_range(UNI_LAST, UNI_FIRST));
                1:       hot_points[i] = 21'($urandom_range(EXA_LAST, EXA_FIRST));
                default: hot_points[i] = 21'($urandom_range(EXB_LAST, EXB_FIRST));
            endcase
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: ASCII extremes, first unified point and last extension B point.
        push_byte(8'h00);
        push_byte(8'h7F);
        push_point(UNI_FIRST, 3, 3);
        push_point(EXB_LAST, 4, 4);
        // Stray continuation byte.
        push_byte(8'h80);
        // Read while a character is open, then finish it (first point of extension A).
        push_byte(8'hE3);
        push_query(UNI_FIRST);
        push_byte(8'h90);
        push_byte(8'h80);
        // Lead byte cut short by an ASCII byte.
        push_byte(8'hE4);
        push_byte(8'h41);
        // Invalid lead bytes.
        push_byte(8'hF8);
        push_byte(8'hFF);
        // Four-byte form decoding past the end of Unicode.
        push_point(21'h1FFFFF, 4, 4);
        // File end drops an open character; the next continuation is stray.
        push_byte(8'hE9);
        push_item(CMD_EOF, 8'hFF, 21'h1FFFFF);
        push_byte(8'hBF);
        // Overlong zero and a surrogate are taken at face value.
        push_point(21'h0, 2, 2);
        push_point(21'h0D800, 3, 3);
        // A bin going to two, reads outside and inside the ranges, idle command.
        push_point(UNI_FIRST, 3, 3);
        push_query(UNI_FIRST);
        push_query(21'h1FFFFF);
        push_item(CMD_NOP, 8'h00, 21'h0);

        // Random part in three idling phases: result side slow, sender slow, no gaps.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 8;
                    sink_idle_pct = 85;
                end
                1: begin
                    src_idle_pct  = 85;
                    sink_idle_pct = 8;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < target)
                random_action();
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then keep watching for stray results.
        while (tally_sb.due_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d input transfers in three idling phases, %0d results checked",
                 items_sent, tally_sb.checked);
        $display("Run: %0d characters, %0d CJK over %0d distinct points, %0d reads, %0d file ends",
                 tally_sb.chars, tally_sb.cjk_chars, tally_sb.distinct, reads_sent,
                 tally_sb.files);
        if (tally_sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: stop a run that hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cch_pkg.sv
hw/rtl/cch_ctrl.sv
hw/rtl/cch_datapath.sv
hw/rtl/cjk_char_histogram.sv
sim/cjk_char_histogram_tb.sv
